[hdl/bcpu_pkg.sv]
// Shared types and constants for the byte CPU execute unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package bcpu_pkg;

    localparam int DATA_W     = 8;
    localparam int DMEM_DEPTH = 256;
    localparam int DMEM_AW    = 8;

    localparam logic [DATA_W-1:0] STEP_SHORT = 8'd3;
    localparam logic [DATA_W-1:0] STEP_LONG  = 8'd4;

    // Codes written by a compare
    localparam logic [DATA_W-1:0] CMP_EQ = 8'd0;
    localparam logic [DATA_W-1:0] CMP_GT = 8'd1;
    localparam logic [DATA_W-1:0] CMP_LT = 8'd2;

    typedef enum logic [3:0] {
        OP_MOV   = 4'd0,
        OP_JMP   = 4'd1,
        OP_STORE = 4'd2,
        OP_LOAD  = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_COMP  = 4'd6,
        OP_JE    = 4'd7,
        OP_JNE   = 4'd8,
        OP_JB    = 4'd9,
        OP_JS    = 4'd10,
        OP_HALT  = 4'd11
    } op_t;

    // Execute decisions handed from the ALU to the state update logic
    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic              halt_next;
        logic [DATA_W-1:0] wv;
        logic              rf_we;
        logic              rf_dst_third;
        logic              dm_we;
    } exec_ctrl_t;

endpackage

`default_nettype wire

[hdl/bcpu_regfile.sv]
// Register file: two registered read ports, one write port, write-first bypass.
// Depends on bcpu_pkg. Per-entry valid bits make unwritten entries read zero.
`default_nettype none

module bcpu_regfile
    import bcpu_pkg::*;
#(
    parameter int NUM_REGS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        ren,
    input  wire logic [$clog2(NUM_REGS)-1:0] raddr0,
    input  wire logic [$clog2(NUM_REGS)-1:0] raddr1,
    input  wire logic                        we,
    input  wire logic [$clog2(NUM_REGS)-1:0] waddr,
    input  wire logic [DATA_W-1:0]           wdata,
    output logic      [DATA_W-1:0]           rdata0,
    output logic      [DATA_W-1:0]           rdata1
);

    logic [DATA_W-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Same-cycle write to the address being read is forwarded
    always_ff @(posedge aclk) begin
        if (ren) begin
            if (we && (waddr == raddr0)) begin
                rdata0_reg <= wdata;
            end else if (valid_reg[raddr0]) begin
                rdata0_reg <= mem[raddr0];
            end else begin
                rdata0_reg <= '0;
            end
            if (we && (waddr == raddr1)) begin
                rdata1_reg <= wdata;
            end else if (valid_reg[raddr1]) begin
                rdata1_reg <= mem[raddr1];
            end else begin
                rdata1_reg <= '0;
            end
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

[hdl/bcpu_dmem.sv]
// 256-byte data memory: one registered read port, one write port, bypass.
// Depends on bcpu_pkg. Per-byte valid bits make unwritten bytes read zero.
`default_nettype none

module bcpu_dmem
    import bcpu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               ren,
    input  wire logic [DMEM_AW-1:0] raddr,
    input  wire logic               we,
    input  wire logic [DMEM_AW-1:0] waddr,
    input  wire logic [DATA_W-1:0]  wdata,
    output logic      [DATA_W-1:0]  rdata
);

    logic [DATA_W-1:0]     mem [DMEM_DEPTH];
    logic [DMEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]     rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else if (valid_reg[raddr]) begin
                rdata_reg <= mem[raddr];
            end else begin
                rdata_reg <= '0;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/bcpu_alu.sv]
// Combinational execute logic: next PC, halt, written value and write enables.
// Depends on bcpu_pkg (op_t, exec_ctrl_t, step and compare constants).
`default_nettype none

module bcpu_alu
    import bcpu_pkg::*;
(
    input  wire op_t               op,
    input  wire logic [DATA_W-1:0] first_op,
    input  wire logic [DATA_W-1:0] second_op,
    input  wire logic [DATA_W-1:0] pc,
    input  wire logic              halt,
    input  wire logic [DATA_W-1:0] ra_val,
    input  wire logic [DATA_W-1:0] rb_val,
    input  wire logic [DATA_W-1:0] mem_val,
    output exec_ctrl_t             ctrl
);

    logic [DATA_W-1:0] pc_short;
    logic [DATA_W-1:0] pc_long;
    logic [DATA_W-1:0] cmp_code;

    assign pc_short = pc + STEP_SHORT;
    assign pc_long  = pc + STEP_LONG;
    assign cmp_code = (ra_val == rb_val) ? CMP_EQ : ((ra_val > rb_val) ? CMP_GT : CMP_LT);

    always_comb begin
        ctrl              = '0;
        ctrl.next_pc      = pc;
        ctrl.halt_next    = halt;
        if (!halt) begin
            unique case (op)
                OP_MOV: begin
                    ctrl.wv      = second_op;
                    ctrl.rf_we   = 1'b1;
                    ctrl.next_pc = pc_short;
                end
                OP_JMP: begin
                    ctrl.next_pc = first_op;
                end
                OP_STORE: begin
                    ctrl.wv      = ra_val;
                    ctrl.dm_we   = 1'b1;
                    ctrl.next_pc = pc_short;
                end
                OP_LOAD: begin
                    ctrl.wv      = mem_val;
                    ctrl.rf_we   = 1'b1;
                    ctrl.next_pc = pc_short;
                end
                OP_ADD: begin
                    ctrl.wv      = ra_val + second_op;
                    ctrl.rf_we   = 1'b1;
                    ctrl.next_pc = pc_short;
                end
                OP_SUB: begin
                    ctrl.wv      = ra_val - second_op;
                    ctrl.rf_we   = 1'b1;
                    ctrl.next_pc = pc_short;
                end
                OP_COMP: begin
                    ctrl.wv           = cmp_code;
                    ctrl.rf_we        = 1'b1;
                    ctrl.rf_dst_third = 1'b1;
                    ctrl.next_pc      = pc_long;
                end
                OP_JE: begin
                    ctrl.next_pc = (ra_val == CMP_EQ) ? second_op : pc_short;
                end
                OP_JNE: begin
                    ctrl.next_pc = (ra_val == CMP_GT || ra_val == CMP_LT) ? second_op : pc_short;
                end
                OP_JB: begin
                    ctrl.next_pc = (ra_val == CMP_GT) ? second_op : pc_short;
                end
                OP_JS: begin
                    ctrl.next_pc = (ra_val == CMP_LT) ? second_op : pc_short;
                end
                OP_HALT: begin
                    ctrl.halt_next = 1'b1;
                end
                default: begin
                    // undefined opcodes act as a no-op
                    ctrl.next_pc = pc_short;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/byte_cpu_execute_unit_top.sv]
// Top level of the byte CPU execute unit: input stage, register file, data
// memory, ALU and result register. Depends on bcpu_pkg, bcpu_regfile, bcpu_dmem, bcpu_alu.
//
//  channel | dir | handshake         | tdata (low bit up)
//  s_      | in  | s_tvalid/s_tready | action[3:0] first[11:4] second[19:12] third[27:20]
//  m_      | out | m_tvalid/m_tready | next_pc[7:0] halted[8] written_value[16:9]
//
// One instruction per cycle sustained while m_tready is high; a taken beat is held in the registered
// reads of both memories and the execute registers, then executed into the result register.
// Register-file and data-memory writes are forwarded to a read issued in the same cycle.
// aresetn clears PC, halt flag, pipeline valids and the per-entry valid bits; no clearing pass.
// With m_tvalid high and m_tready low the result register holds, a full execute stage holds and s_tready is low.
`default_nettype none

module byte_cpu_execute_unit_top
    import bcpu_pkg::*;
#(
    parameter int NUM_REGS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // action, first_operand, second_operand, third_operand
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // next_pc, halted, written_value
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [3:0]        in_action;
    logic [DATA_W-1:0] in_first;
    logic [DATA_W-1:0] in_second;
    logic [DATA_W-1:0] in_third;
    logic [3:0]        unused_pad;

    assign in_action  = s_tdata[3:0];
    assign in_first   = s_tdata[11:4];
    assign in_second  = s_tdata[19:12];
    assign in_third   = s_tdata[27:20];
    assign unused_pad = s_tdata[31:28];

    // Register index reduction, built as a constant table at elaboration
    logic [IDX_W-1:0] idx_tab [DMEM_DEPTH];
    for (genvar g = 0; g < DMEM_DEPTH; g++) begin : g_idx
        assign idx_tab[g] = IDX_W'(g % NUM_REGS);
    end

    logic accept;
    logic fire;
    logic out_free;

    logic              ex_valid_reg;
    op_t               ex_op_reg;
    logic [DATA_W-1:0] ex_first_reg;
    logic [DATA_W-1:0] ex_second_reg;
    logic [IDX_W-1:0]  ex_ra_reg;
    logic [IDX_W-1:0]  ex_rc_reg;

    logic [DATA_W-1:0] pc_reg;
    logic              halt_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_pc_reg;
    logic              m_halted_reg;
    logic [DATA_W-1:0] m_wv_reg;

    logic [DATA_W-1:0] ra_val;
    logic [DATA_W-1:0] rb_val;
    logic [DATA_W-1:0] mem_val;
    exec_ctrl_t        ctrl;
    logic              rf_we;
    logic [IDX_W-1:0]  rf_waddr;
    logic              dm_we;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = ex_valid_reg && out_free;
    assign s_tready = !ex_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (accept) begin
            ex_valid_reg <= 1'b1;
        end else if (fire) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_op_reg     <= op_t'(in_action);
            ex_first_reg  <= in_first;
            ex_second_reg <= in_second;
            ex_ra_reg     <= idx_tab[in_first];
            ex_rc_reg     <= idx_tab[in_third];
        end
    end

    assign rf_we    = fire && ctrl.rf_we;
    assign rf_waddr = ctrl.rf_dst_third ? ex_rc_reg : ex_ra_reg;
    assign dm_we    = fire && ctrl.dm_we;

    bcpu_regfile #(
        .NUM_REGS(NUM_REGS)
    ) u_regfile (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ren    (accept),
        .raddr0 (idx_tab[in_first]),
        .raddr1 (idx_tab[in_second]),
        .we     (rf_we),
        .waddr  (rf_waddr),
        .wdata  (ctrl.wv),
        .rdata0 (ra_val),
        .rdata1 (rb_val)
    );

    bcpu_dmem u_dmem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ren    (accept),
        .raddr  (in_second),
        .we     (dm_we),
        .waddr  (ex_second_reg),
        .wdata  (ctrl.wv),
        .rdata  (mem_val)
    );

    bcpu_alu u_alu (
        .op       (ex_op_reg),
        .first_op (ex_first_reg),
        .second_op(ex_second_reg),
        .pc       (pc_reg),
        .halt     (halt_reg),
        .ra_val   (ra_val),
        .rb_val   (rb_val),
        .mem_val  (mem_val),
        .ctrl     (ctrl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            halt_reg <= 1'b0;
        end else if (fire) begin
            pc_reg   <= ctrl.next_pc;
            halt_reg <= ctrl.halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_pc_reg     <= ctrl.next_pc;
            m_halted_reg <= ctrl.halt_next;
            m_wv_reg     <= ctrl.wv;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_wv_reg, m_halted_reg, m_pc_reg};

    logic [3:0] unused_sink;
    assign unused_sink = unused_pad;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared after being set");

    a_no_write_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> !(rf_we || dm_we))
        else $error("state written while halted");

    a_ex_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && !fire) |=> ex_valid_reg)
        else $error("execute stage dropped an instruction");

    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_tvalid && m_tdata[7:0] == pc_reg))
        else $error("result beat does not match committed PC");
`endif

endmodule

`default_nettype wire
